[sv/tts_pkg.sv]
// ---------------------------------------------------------------------------
// tts_pkg: shared types and constants of the tick task scheduler table
// Request kinds, result status codes, controller states and the command and
// status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package tts_pkg;

  localparam int SLOTS    = 8;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int INDEX_W  = 4;
  localparam int TAG_W    = 8;
  localparam int TIME_W   = 16;
  localparam int COUNT_W  = 8;
  localparam int STATUS_W = 3;

  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_ADD      = 2'd1,
    KIND_DELETE   = 2'd2,
    KIND_DISPATCH = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 3'd0,
    ST_ADDED   = 3'd1,
    ST_FULL    = 3'd2,
    ST_RUN     = 3'd3,
    ST_DELETED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_DISP,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic do_add;
    logic do_delete;
    logic walk_clr;
    logic tick_step;
    logic disp_step;
    logic emit_done;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_end;
  } stat_t;

endpackage

[sv/tts_ctrl.sv]
// ---------------------------------------------------------------------------
// tts_ctrl: request sequencer
// Decodes each accepted request and steps the slot walk for tick and dispatch.
// ---------------------------------------------------------------------------
module tts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [1:0]     kind_i,
  input  tts_pkg::stat_t stat_i,
  output tts_pkg::cmd_t  cmd_o,
  output logic           busy_o
);
  import tts_pkg::*;

  state_e state_q, state_d;
  kind_e  kind;

  assign kind = kind_e'(kind_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (kind == KIND_TICK) begin
            state_d = S_TICK;
          end else if (kind == KIND_DISPATCH) begin
            state_d = S_DISP;
          end
        end
      end
      S_TICK: begin
        if (stat_i.walk_end) begin
          state_d = S_IDLE;
        end
      end
      S_DISP: begin
        if (stat_i.walk_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          case (kind)
            KIND_ADD:    cmd_o.do_add    = 1'b1;
            KIND_DELETE: cmd_o.do_delete = 1'b1;
            default:     cmd_o.walk_clr  = 1'b1;
          endcase
        end
      end
      S_TICK:  cmd_o.tick_step = 1'b1;
      S_DISP:  cmd_o.disp_step = 1'b1;
      S_DONE:  cmd_o.emit_done = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

endmodule

[sv/tts_dpath.sv]
// ---------------------------------------------------------------------------
// tts_dpath: slot table, walk index and result register
// Holds the task slots, applies add, delete, tick and dispatch steps one slot
// at a time and drives the registered result.
// ---------------------------------------------------------------------------
module tts_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tts_pkg::cmd_t                 cmd_i,
  output tts_pkg::stat_t                stat_o,
  input  logic [tts_pkg::TAG_W-1:0]     task_tag_i,
  input  logic [tts_pkg::TIME_W-1:0]    first_delay_i,
  input  logic [tts_pkg::TIME_W-1:0]    period_i,
  input  logic [2:0]                    slot_i,
  output logic                          valid_o,
  output logic [tts_pkg::INDEX_W-1:0]   slot_index_o,
  output logic [tts_pkg::TAG_W-1:0]     run_tag_o,
  output logic [tts_pkg::STATUS_W-1:0]  status_o,
  output logic                          last_o
);
  import tts_pkg::*;

  localparam logic [COUNT_W-1:0] CountMax = '1;

  logic [SLOTS-1:0]   valid_q;
  logic [TAG_W-1:0]   tag_q    [SLOTS];
  logic [TIME_W-1:0]  delay_q  [SLOTS];
  logic [TIME_W-1:0]  period_q [SLOTS];
  logic [COUNT_W-1:0] count_q  [SLOTS];

  logic [SLOT_W-1:0]  idx_q;
  logic [SLOT_W-1:0]  free_idx;
  logic               full;

  logic                strobe_q;
  logic [INDEX_W-1:0]  index_q;
  logic [TAG_W-1:0]    rtag_q;
  status_e             status_q;
  logic                last_q;

  // current walk slot
  logic               cur_valid;
  logic [TAG_W-1:0]   cur_tag;
  logic [TIME_W-1:0]  cur_delay;
  logic [TIME_W-1:0]  cur_period;
  logic [COUNT_W-1:0] cur_count;
  logic               cur_due;
  logic               del_in_range;

  assign cur_valid    = valid_q[idx_q];
  assign cur_tag      = tag_q[idx_q];
  assign cur_delay    = delay_q[idx_q];
  assign cur_period   = period_q[idx_q];
  assign cur_count    = count_q[idx_q];
  assign cur_due      = cur_valid && (cur_count != '0);
  assign del_in_range = (32'(slot_i) < SLOTS);

  assign stat_o.walk_end = (idx_q == SLOT_W'(SLOTS - 1));

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end
  assign full = &valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.walk_clr) begin
      idx_q <= '0;
    end else if (cmd_i.tick_step || cmd_i.disp_step) begin
      idx_q <= idx_q + SLOT_W'(1);
    end
  end

  // slot table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        tag_q[i]    <= '0;
        delay_q[i]  <= '0;
        period_q[i] <= '0;
        count_q[i]  <= '0;
      end
    end else begin
      if (cmd_i.do_add && !full) begin
        valid_q[free_idx]  <= 1'b1;
        tag_q[free_idx]    <= task_tag_i;
        delay_q[free_idx]  <= first_delay_i;
        period_q[free_idx] <= period_i;
        count_q[free_idx]  <= '0;
      end
      if (cmd_i.do_delete && del_in_range) begin
        valid_q[slot_i[SLOT_W-1:0]]  <= 1'b0;
        tag_q[slot_i[SLOT_W-1:0]]    <= '0;
        delay_q[slot_i[SLOT_W-1:0]]  <= '0;
        period_q[slot_i[SLOT_W-1:0]] <= '0;
        count_q[slot_i[SLOT_W-1:0]]  <= '0;
      end
      if (cmd_i.tick_step && cur_valid) begin
        if (cur_delay == '0) begin
          if (cur_count != CountMax) begin
            count_q[idx_q] <= cur_count + COUNT_W'(1);
          end
          if (cur_period != '0) begin
            delay_q[idx_q] <= cur_period - TIME_W'(1);
          end
        end else begin
          delay_q[idx_q] <= cur_delay - TIME_W'(1);
        end
      end
      if (cmd_i.disp_step && cur_due) begin
        if (cur_period == '0) begin
          // one-shot task: drop the slot
          valid_q[idx_q]  <= 1'b0;
          tag_q[idx_q]    <= '0;
          delay_q[idx_q]  <= '0;
          period_q[idx_q] <= '0;
          count_q[idx_q]  <= '0;
        end else begin
          count_q[idx_q] <= cur_count - COUNT_W'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.do_add || cmd_i.do_delete || cmd_i.emit_done ||
                  (cmd_i.disp_step && cur_due);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_add) begin
      index_q  <= full ? INDEX_W'(SLOTS) : INDEX_W'(free_idx);
      rtag_q   <= '0;
      status_q <= full ? ST_FULL : ST_ADDED;
      last_q   <= 1'b1;
    end else if (cmd_i.do_delete) begin
      index_q  <= INDEX_W'(slot_i);
      rtag_q   <= '0;
      status_q <= ST_DELETED;
      last_q   <= 1'b1;
    end else if (cmd_i.disp_step && cur_due) begin
      index_q  <= INDEX_W'(idx_q);
      rtag_q   <= cur_tag;
      status_q <= ST_RUN;
      last_q   <= 1'b0;
    end else if (cmd_i.emit_done) begin
      index_q  <= '0;
      rtag_q   <= '0;
      status_q <= ST_DONE;
      last_q   <= 1'b1;
    end
  end

  assign valid_o      = strobe_q;
  assign slot_index_o = index_q;
  assign run_tag_o    = rtag_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

endmodule

[sv/tick_task_scheduler_table.sv]
// ---------------------------------------------------------------------------
// tick_task_scheduler_table: time-triggered cooperative task table
// Eight task slots with delay, period and pending-run count per slot.
// ---------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start_i high and busy low.
//   kind_i selects tick, add, delete or dispatch; the other inputs carry
//   the tag, first delay, period and slot for add and delete.
//   Each result appears for exactly one cycle with valid_o high; the
//   receiver must take it then, since it cannot stall the block.
// Latency and throughput:
//   Add and delete finish in the accept cycle; their single result shows
//   the next cycle and busy stays low, so one may follow every cycle.
//   Tick walks the table one slot per cycle, busy until the last slot is
//   visited, with no result. Dispatch walks the same way, giving a run
//   result in the cycle after each due slot is visited, then a done result
//   once the walk ends; busy stays high through the walk and the done step.
//   A single walk index over the slot table drives both walks.
// Reset:
//   rst_ni clears every slot, the walk and the result strobe at once.
// ---------------------------------------------------------------------------
module tick_task_scheduler_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy,
  input  logic [1:0]                    kind_i,
  input  logic [tts_pkg::TAG_W-1:0]     task_tag_i,
  input  logic [tts_pkg::TIME_W-1:0]    first_delay_i,
  input  logic [tts_pkg::TIME_W-1:0]    period_i,
  input  logic [2:0]                    slot_i,
  output logic                          valid_o,
  output logic [tts_pkg::INDEX_W-1:0]   slot_index_o,
  output logic [tts_pkg::TAG_W-1:0]     run_tag_o,
  output logic [tts_pkg::STATUS_W-1:0]  status_o,
  output logic                          last_o
);
  import tts_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequence each request: decode, then step the slot walk
  tts_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .kind_i  (kind_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // hold the table and drive the result
  tts_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .task_tag_i    (task_tag_i),
    .first_delay_i (first_delay_i),
    .period_i      (period_i),
    .slot_i        (slot_i),
    .valid_o       (valid_o),
    .slot_index_o  (slot_index_o),
    .run_tag_o     (run_tag_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule
